// ===== rtl/stq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package stq_pkg;

    localparam int QUEUE_DEPTH_DEF = 32;
    localparam int MAX_RESULTS     = 32;
    localparam int FIRE_W          = $clog2(MAX_RESULTS);
    localparam int DATA_W          = 32;

    localparam logic CMD_ADD     = 1'b0;
    localparam logic CMD_TICK    = 1'b1;
    localparam logic KIND_FIRED  = 1'b0;
    localparam logic KIND_REJECT = 1'b1;

    typedef struct packed {
        logic              cmd;
        logic [DATA_W-1:0] delay;
        logic [DATA_W-1:0] tag;
    } t_in_item;

    typedef struct packed {
        logic              kind;
        logic [DATA_W-1:0] fired_tag;
        logic              last;
    } t_out_item;

    typedef struct packed {
        logic              vld;
        logic [DATA_W-1:0] delay;
        logic [DATA_W-1:0] tag;
    } t_cell_data;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_DECR,
        CELL_SHIFT
    } t_cell_op;

    typedef struct packed {
        t_cell_op          op;
        logic [DATA_W-1:0] delay;
        logic [DATA_W-1:0] tag;
    } t_cell_ctrl;

    typedef enum logic {
        ST_IDLE,
        ST_FIRE
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/stq_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module stq_cell (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  stq_pkg::t_cell_ctrl i_ctrl,
    input  stq_pkg::t_cell_data i_left,
    input  wire                 i_left_keep,
    input  stq_pkg::t_cell_data i_right,
    output stq_pkg::t_cell_data o_data,
    output logic                o_keep
);
    import stq_pkg::*;

    logic              r_vld;
    logic [DATA_W-1:0] r_delay;
    logic [DATA_W-1:0] r_tag;
    logic              n_vld;
    logic [DATA_W-1:0] n_delay;
    logic [DATA_W-1:0] n_tag;

    // an entry stays put when it sorts at or before the new timer
    assign o_keep = r_vld && (r_delay <= i_ctrl.delay);

    assign o_data.vld   = r_vld;
    assign o_data.delay = r_delay;
    assign o_data.tag   = r_tag;

    always_comb begin
        n_vld   = r_vld;
        n_delay = r_delay;
        n_tag   = r_tag;
        case (i_ctrl.op)
            CELL_INSERT: begin
                if (!o_keep) begin
                    if (i_left_keep) begin
                        n_vld   = 1'b1;
                        n_delay = i_ctrl.delay;
                        n_tag   = i_ctrl.tag;
                    end else begin
                        n_vld   = i_left.vld;
                        n_delay = i_left.delay;
                        n_tag   = i_left.tag;
                    end
                end
            end
            CELL_DECR: begin
                if (r_delay != '0) begin
                    n_delay = r_delay - DATA_W'(1);
                end
            end
            CELL_SHIFT: begin
                n_vld   = i_right.vld;
                n_delay = i_right.delay;
                n_tag   = i_right.tag;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_delay <= n_delay;
        r_tag   <= n_tag;
    end

endmodule

`default_nettype wire

// ===== rtl/sorted_timer_queue.sv =====
// Add: a zero-delay or rejected add puts its result in the output register on the next cycle;
// a stored add is written into the cell chain registers.
// Tick: counts down every cell, then one result per cycle while the output is not stalled, set by the
// one-place shift of the chain toward the head and the single output register.
// Synchronous active-low reset empties the queue (cell valid bits) and the output register.
`timescale 1ns / 1ps
`default_nettype none

module sorted_timer_queue #(
    parameter int QUEUE_DEPTH = stq_pkg::QUEUE_DEPTH_DEF
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    output logic               o_in_stall,
    input  stq_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  wire                i_out_stall,
    output stq_pkg::t_out_item o_out_item
);
    import stq_pkg::*;

    t_cell_data w_cell [QUEUE_DEPTH];
    logic       w_keep [QUEUE_DEPTH];
    t_cell_ctrl w_ctrl;

    t_state            r_state;
    t_state            n_state;
    logic [FIRE_W-1:0] r_fire_cnt;
    logic [FIRE_W-1:0] n_fire_cnt;
    logic              r_out_valid;
    logic              n_out_valid;
    t_out_item         r_out_item;
    t_out_item         n_out_item;

    logic out_free;
    logic in_acc;
    logic full;
    logic head_zero;
    logic fire_last;

    t_cell_data c_empty;
    assign c_empty = '{vld: 1'b0, delay: '0, tag: '0};

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        t_cell_data w_left;
        t_cell_data w_right;
        logic       w_left_keep;
        if (g == 0) begin : g_head
            assign w_left      = c_empty;
            assign w_left_keep = 1'b1;
        end else begin : g_mid
            assign w_left      = w_cell[g-1];
            assign w_left_keep = w_keep[g-1];
        end
        if (g == QUEUE_DEPTH - 1) begin : g_tail
            assign w_right = c_empty;
        end else begin : g_body
            assign w_right = w_cell[g+1];
        end
        stq_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctrl      (w_ctrl),
            .i_left      (w_left),
            .i_left_keep (w_left_keep),
            .i_right     (w_right),
            .o_data      (w_cell[g]),
            .o_keep      (w_keep[g])
        );
    end

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = !((r_state == ST_IDLE) && out_free);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign full       = w_cell[QUEUE_DEPTH-1].vld;
    assign head_zero  = w_cell[0].vld && (w_cell[0].delay == '0);
    // next head not expired, or the per-tick result limit is reached
    assign fire_last  = !(w_cell[1].vld && (w_cell[1].delay == '0))
                        || (r_fire_cnt == FIRE_W'(MAX_RESULTS - 1));

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    always_comb begin
        w_ctrl.op    = CELL_HOLD;
        w_ctrl.delay = i_in_item.delay;
        w_ctrl.tag   = i_in_item.tag;
        n_state      = r_state;
        n_fire_cnt   = r_fire_cnt;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_item   = r_out_item;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_in_item.cmd == CMD_TICK) begin
                        w_ctrl.op  = CELL_DECR;
                        n_state    = ST_FIRE;
                        n_fire_cnt = '0;
                    end else if (i_in_item.delay == '0) begin
                        n_out_valid = 1'b1;
                        n_out_item  = '{kind: KIND_FIRED, fired_tag: i_in_item.tag,
                                        last: 1'b1};
                    end else if (full) begin
                        n_out_valid = 1'b1;
                        n_out_item  = '{kind: KIND_REJECT, fired_tag: i_in_item.tag,
                                        last: 1'b1};
                    end else begin
                        w_ctrl.op = CELL_INSERT;
                    end
                end
            end
            ST_FIRE: begin
                if (!head_zero) begin
                    n_state = ST_IDLE;
                end else if (out_free) begin
                    w_ctrl.op   = CELL_SHIFT;
                    n_out_valid = 1'b1;
                    n_out_item  = '{kind: KIND_FIRED, fired_tag: w_cell[0].tag,
                                    last: fire_last};
                    n_fire_cnt  = r_fire_cnt + FIRE_W'(1);
                    if (fire_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fire_cnt  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fire_cnt  <= n_fire_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_item <= n_out_item;
    end

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    import stq_pkg::*;

    localparam int QDEPTH      = QUEUE_DEPTH_DEF;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_LEN    = 400;
    localparam int SETTLE      = 40;

    typedef struct packed {
        logic [DATA_W-1:0] delay;
        logic [DATA_W-1:0] tag;
    } t_timer;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_item  i_in_item   = '0;
    logic      i_out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_item;

    // shadow of the queue contents and the results still owed by the block
    t_timer    timer_list[$];
    t_out_item pending_fires[$];

    bit tx_idle_en = 1'b0;
    bit rx_idle_en = 1'b0;
    int hold_asks  = 0;
    int hold_seen  = 0;
    int hold_left  = 0;

    int cycle_cnt   = 0;
    int err_cnt     = 0;
    int items_sent  = 0;
    int fired_cnt   = 0;
    int reject_cnt  = 0;
    int burst_len   = 0;
    int burst_max   = 0;

    sorted_timer_queue #(
        .QUEUE_DEPTH(QDEPTH)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, pending_fires.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic t_in_item mk_item(logic cmd, logic [DATA_W-1:0] d,
                                         logic [DATA_W-1:0] t);
        t_in_item it;
        it.cmd   = cmd;
        it.delay = d;
        it.tag   = t;
        return it;
    endfunction

    // Expected results of one accepted transaction.
    function automatic void predict_item(t_in_item it);
        int        n;
        int        k;
        int        pos;
        t_out_item res;
        t_timer    ent;
        if (it.cmd == CMD_TICK) begin
            for (k = 0; k < timer_list.size(); k++)
                if (timer_list[k].delay != '0)
                    timer_list[k].delay = timer_list[k].delay - 1'b1;
            n = 0;
            while (n < timer_list.size() && n < MAX_RESULTS && timer_list[n].delay == '0)
                n++;
            for (k = 0; k < n; k++) begin
                res.kind      = KIND_FIRED;
                res.fired_tag = timer_list[0].tag;
                res.last      = (k == n - 1);
                pending_fires.push_back(res);
                void'(timer_list.pop_front());
            end
        end else if (it.delay == '0) begin
            res.kind      = KIND_FIRED;
            res.fired_tag = it.tag;
            res.last      = 1'b1;
            pending_fires.push_back(res);
        end else if (timer_list.size() >= QDEPTH) begin
            res.kind      = KIND_REJECT;
            res.fired_tag = it.tag;
            res.last      = 1'b1;
            pending_fires.push_back(res);
        end else begin
            // goes behind every entry with an equal or smaller delay
            pos = 0;
            while (pos < timer_list.size() && timer_list[pos].delay <= it.delay)
                pos++;
            ent.delay = it.delay;
            ent.tag   = it.tag;
            timer_list.insert(pos, ent);
        end
    endfunction

    task automatic send_item(input t_in_item it);
        while (tx_idle_en && $urandom_range(99) < 33) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        predict_item(it);
        items_sent++;
    endtask

    // Pause the sender until every owed result is in, then let the block settle.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_fires.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // receiver: random stall, or a long hold-off when a test asks for one
    always @(posedge i_clk) begin
        if (hold_seen != hold_asks) begin
            hold_seen   <= hold_asks;
            hold_left   <= HOLD_LEN;
            i_out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (rx_idle_en) begin
            i_out_stall <= ($urandom_range(99) < 33);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    task automatic report_mismatch(input string what, input t_out_item want,
                                   input t_out_item got);
        err_cnt++;
        if (err_cnt <= 10)
            $display("[%0t] %s: exp kind=%0d tag=%h last=%0d, got kind=%0d tag=%h last=%0d",
                     $time, what, want.kind, want.fired_tag, want.last,
                     got.kind, got.fired_tag, got.last);
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        t_out_item got;
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            got = o_out_item;
            if (pending_fires.size() == 0) begin
                report_mismatch("unexpected result", '0, got);
            end else begin
                want = pending_fires.pop_front();
                if (got.kind !== want.kind || got.fired_tag !== want.fired_tag
                    || got.last !== want.last)
                    report_mismatch("result mismatch", want, got);
                if (want.kind == KIND_REJECT)
                    reject_cnt++;
                else
                    fired_cnt++;
            end
            burst_len++;
            if (got.last === 1'b1) begin
                if (burst_len > burst_max)
                    burst_max = burst_len;
                burst_len = 0;
            end
        end
    end

    // Zero-delay adds, tick on empty, tie order, sorted insert, tick with no expiry.
    task automatic test_ordering();
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        send_item(mk_item(CMD_TICK, $urandom(), $urandom()));
        send_item(mk_item(CMD_ADD, 32'h0000_0000, 32'h0000_0000));
        send_item(mk_item(CMD_ADD, 32'h0000_0000, 32'hFFFF_FFFF));
        send_item(mk_item(CMD_ADD, 32'hFFFF_FFFF, 32'h5A5A_0001));
        send_item(mk_item(CMD_ADD, 32'd3, 32'hA000_0003));
        send_item(mk_item(CMD_ADD, 32'd1, 32'hB000_0001));
        send_item(mk_item(CMD_ADD, 32'd3, 32'hC000_0003));
        send_item(mk_item(CMD_ADD, 32'd2, 32'hD000_0002));
        send_item(mk_item(CMD_ADD, 32'd1, 32'hE000_0001));
        repeat (3) send_item(mk_item(CMD_TICK, $urandom(), $urandom()));
        send_item(mk_item(CMD_TICK, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        drain_results();
    endtask

    // Fill to capacity, reject past it, zero delay while full, then a big burst.
    task automatic test_full_queue();
        int k;
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b1;
        for (k = timer_list.size(); k < QDEPTH; k++)
            send_item(mk_item(CMD_ADD, 32'd1 + (k % 2), 32'hF000_0000 | k));
        send_item(mk_item(CMD_ADD, 32'd5, 32'hDEAD_BEEF));
        send_item(mk_item(CMD_ADD, 32'h7FFF_FFFF, 32'h0F0F_0F0F));
        send_item(mk_item(CMD_ADD, 32'd0, 32'h1234_5678));
        send_item(mk_item(CMD_TICK, $urandom(), $urandom()));
        send_item(mk_item(CMD_TICK, $urandom(), $urandom()));
        drain_results();
    endtask

    // Receiver holds off while the sender keeps pushing; block must stall its input.
    task automatic test_backpressure();
        int k;
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        hold_asks++;
        for (k = 0; k < 36; k++) begin
            if (k % 5 == 4)
                send_item(mk_item(CMD_TICK, $urandom(), $urandom()));
            else if (k % 7 == 3)
                send_item(mk_item(CMD_ADD, 32'd0, $urandom()));
            else
                send_item(mk_item(CMD_ADD, $urandom_range(1, 3), $urandom()));
        end
        repeat (3) send_item(mk_item(CMD_TICK, $urandom(), $urandom()));
        drain_results();
        rx_idle_en = 1'b1;
    endtask

    task automatic test_random(input int n_items);
        int                i;
        int                k;
        int                r;
        int                add_run;
        int                long_cnt;
        logic [DATA_W-1:0] d;
        add_run = 0;
        // opening stretch runs with no idling on either side
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        for (i = 0; i < n_items; i++) begin
            if (i == 60) begin
                tx_idle_en = 1'b1;
                rx_idle_en = 1'b1;
            end
            if (i == n_items / 2)
                drain_results();
            long_cnt = 0;
            for (k = 0; k < timer_list.size(); k++)
                if (timer_list[k].delay > 32'd4096)
                    long_cnt++;
            r = $urandom_range(99);
            if (add_run > 0) begin
                add_run--;
                d = $urandom_range(1, 6);
                send_item(mk_item(CMD_ADD, d, $urandom()));
            end else if (r < 4) begin
                add_run = $urandom_range(5, 14);
                send_item(mk_item(CMD_TICK, $urandom(), $urandom()));
            end else if (r < 10) begin
                send_item(mk_item(CMD_ADD, 32'd0, $urandom()));
            end else if (r < 13 && long_cnt < 5) begin
                // long timers never expire in this run; keep only a few
                d = $urandom();
                if (d <= 32'd4096)
                    d = d | 32'h8000_0000;
                send_item(mk_item(CMD_ADD, d, $urandom()));
            end else if (r < 55) begin
                d = $urandom_range(1, 6);
                send_item(mk_item(CMD_ADD, d, $urandom()));
            end else begin
                send_item(mk_item(CMD_TICK, $urandom(), $urandom()));
            end
        end
        drain_results();
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_ordering();
        test_full_queue();
        test_backpressure();
        test_random(140);
        if (pending_fires.size() != 0)
            err_cnt++;
        $display("Run covered %0d input transactions: %0d timers fired, %0d adds rejected",
                 items_sent, fired_cnt, reject_cnt);
        $display("Longest burst %0d results, %0d mismatches in %0d cycles",
                 burst_max, err_cnt, cycle_cnt);
        if (err_cnt == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
